[rtl/nfa_pkg.sv]
// ----------------------------------------------------------------------------
// nfa_pkg
// Shared types, codes and constants of the next-fit boundary-tag allocator.
// ----------------------------------------------------------------------------
package nfa_pkg;

   localparam int HEAP_WORDS_DEFAULT = 65536;

   localparam int ADDR_W  = 18;
   localparam int BREAK_W = 19;
   localparam int CHUNK_W = 17;
   localparam int REQ_W   = 19;
   localparam int WORD_W  = 32;

   localparam logic [WORD_W-1:0] SIZE_MASK      = ~32'h7;
   localparam logic [WORD_W-1:0] ALLOC_BIT      = 32'h1;
   localparam logic [WORD_W-1:0] MIN_BLOCK      = 32'd16;
   localparam logic [WORD_W-1:0] PROLOGUE_TAG   = 32'h9;
   localparam logic [WORD_W-1:0] PAD_WORD       = 32'h0;
   localparam logic [WORD_W-1:0] LAYOUT_BYTES   = 32'd16;
   localparam logic [ADDR_W-1:0] LIST_START_OK  = 18'd8;
   localparam logic [BREAK_W-1:0] HEAP_LIMIT_RST = 19'd262143 + 19'd1;
   localparam logic [CHUNK_W-1:0] CHUNK_RST      = 17'd4096;

   localparam logic [1:0] CMD_INIT  = 2'd0;
   localparam logic [1:0] CMD_ALLOC = 2'd1;
   localparam logic [1:0] CMD_FREE  = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_ZERO_SIZE = 2'd1;
   localparam logic [1:0] ST_NO_MEMORY = 2'd2;
   localparam logic [1:0] ST_INIT_FAIL = 2'd3;

   localparam logic CSR_HEAP_LIMIT = 1'b0;
   localparam logic CSR_CHUNK      = 1'b1;

   typedef struct packed {
      logic [1:0]        command;
      logic [REQ_W-1:0]  request_bytes;
      logic [ADDR_W-1:0] block_address;
   } req_payload_type;

   typedef struct packed {
      logic [ADDR_W-1:0] payload_address;
      logic [1:0]        status;
   } rsp_payload_type;

   typedef struct packed {
      logic [BREAK_W-1:0] heap_limit_bytes;
      logic [CHUNK_W-1:0] chunk_bytes;
   } cfg_type;

   typedef enum logic [1:0] {
      CTX_INIT,
      CTX_ALLOC,
      CTX_FREE
   } ctx_type;

   typedef enum logic [5:0] {
      S_IDLE,
      S_DISPATCH,
      S_INIT_W0,
      S_INIT_W1,
      S_INIT_W2,
      S_INIT_W3,
      S_EXT,
      S_EXT_W0,
      S_EXT_W1,
      S_EXT_W2,
      S_MRG_A,
      S_MRG_B,
      S_MRG_C,
      S_MRG_D,
      S_MRG_W0,
      S_MRG_W1,
      S_MRG_RET,
      S_SRCH_RD,
      S_SRCH_CHK,
      S_CARVE_A,
      S_CARVE_B,
      S_CARVE_W0,
      S_CARVE_W1,
      S_CARVE_W2,
      S_CARVE_W3,
      S_FREE_RD,
      S_FREE_CHK,
      S_FREE_W0,
      S_FREE_W1,
      S_DONE
   } state_type;

endpackage

[rtl/nfa_ram.sv]
// ----------------------------------------------------------------------------
// nfa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module nfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/nfa_seq.sv]
// ----------------------------------------------------------------------------
// nfa_seq
// Command sequencer: walks and rewrites boundary tags through the heap RAM.
// ----------------------------------------------------------------------------
module nfa_seq
   import nfa_pkg::*;
#(
   parameter int HEAP_WORDS = HEAP_WORDS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  req_payload_type               req,
   input  cfg_type                       cfg,
   input  logic                          out_free,
   output logic                          ready,
   output logic                          done,
   output rsp_payload_type               rsp,
   output logic                          ram_we,
   output logic [$clog2(HEAP_WORDS)-1:0] ram_waddr,
   output logic [WORD_W-1:0]             ram_wdata,
   output logic [$clog2(HEAP_WORDS)-1:0] ram_raddr,
   input  logic [WORD_W-1:0]             ram_rdata
);

   localparam int AW = $clog2(HEAP_WORDS);
   localparam int CW = AW + 1;
   localparam logic [CW-1:0]     N_MAX = CW'(HEAP_WORDS);
   localparam logic [WORD_W-1:0] PHYS  = WORD_W'(HEAP_WORDS * 4);

   state_type          state_ff, state_in;
   ctx_type            ctx_ff, ctx_in;
   req_payload_type    req_ff, req_in;
   logic [BREAK_W-1:0] break_ff, break_in;
   logic [ADDR_W-1:0]  rover_ff, rover_in;
   logic [ADDR_W-1:0]  list_ff, list_in;
   logic [WORD_W-1:0]  bp_ff, bp_in;
   logic [WORD_W-1:0]  asize_ff, asize_in;
   logic [WORD_W-1:0]  ext_ff, ext_in;
   logic [WORD_W-1:0]  msize_ff, msize_in;
   logic [WORD_W-1:0]  prev_ff, prev_in;
   logic [CW-1:0]      n_ff, n_in;
   logic               phase_ff, phase_in;
   logic               split_ff, split_in;
   logic [ADDR_W-1:0]  res_addr_ff, res_addr_in;
   logic [1:0]         res_status_ff, res_status_in;

   logic [WORD_W-1:0] limit;
   logic [WORD_W-1:0] break32;
   logic [WORD_W-1:0] rover32;
   logic [WORD_W-1:0] list32;
   logic [WORD_W-1:0] rd_size;
   logic [WORD_W-1:0] esize;
   logic [WORD_W-1:0] chunk32;
   logic [WORD_W-1:0] tot;
   logic [WORD_W-1:0] ext_pick;
   logic [WORD_W:0]   grow_sum;
   logic [WORD_W:0]   end_sum;

   function automatic logic [AW-1:0] widx(input logic [WORD_W-1:0] off);
      return off[AW+1:2];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         break_ff <= '0;
         rover_ff <= '0;
         list_ff  <= '0;
      end else begin
         state_ff <= state_in;
         break_ff <= break_in;
         rover_ff <= rover_in;
         list_ff  <= list_in;
      end
   end

   always_ff @(posedge clock) begin
      ctx_ff        <= ctx_in;
      req_ff        <= req_in;
      bp_ff         <= bp_in;
      asize_ff      <= asize_in;
      ext_ff        <= ext_in;
      msize_ff      <= msize_in;
      prev_ff       <= prev_in;
      n_ff          <= n_in;
      phase_ff      <= phase_in;
      split_ff      <= split_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
   end

   assign break32 = WORD_W'(break_ff);
   assign rover32 = WORD_W'(rover_ff);
   assign list32  = WORD_W'(list_ff);
   assign chunk32 = WORD_W'(cfg.chunk_bytes);
   assign limit   = (WORD_W'(cfg.heap_limit_bytes) < PHYS) ?
                    WORD_W'(cfg.heap_limit_bytes) : PHYS;
   assign rd_size = ram_rdata & SIZE_MASK;

   // extension size: even word count, at least one minimum block
   always_comb begin
      esize = (ext_ff + 32'd4) & SIZE_MASK;
      if (esize < MIN_BLOCK) begin
         esize = MIN_BLOCK;
      end
   end

   assign grow_sum = {1'b0, break32} + {1'b0, esize};
   assign end_sum  = {1'b0, bp_ff} + {1'b0, rd_size};
   assign tot      = msize_ff + (ram_rdata[0] ? '0 : rd_size)
                              + (prev_ff[0] ? '0 : (prev_ff & SIZE_MASK));
   assign ext_pick = (asize_ff > chunk32) ? asize_ff : chunk32;

   always_comb begin
      state_in      = state_ff;
      ctx_in        = ctx_ff;
      req_in        = req_ff;
      break_in      = break_ff;
      rover_in      = rover_ff;
      list_in       = list_ff;
      bp_in         = bp_ff;
      asize_in      = asize_ff;
      ext_in        = ext_ff;
      msize_in      = msize_ff;
      prev_in       = prev_ff;
      n_in          = n_ff;
      phase_in      = phase_ff;
      split_in      = split_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = '0;
      ram_raddr     = '0;
      done          = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            res_addr_in   = '0;
            res_status_in = ST_OK;
            unique case (req_ff.command)
               CMD_INIT: begin
                  if (LAYOUT_BYTES > limit) begin
                     break_in      = '0;
                     rover_in      = '0;
                     list_in       = '0;
                     res_status_in = ST_INIT_FAIL;
                     state_in      = S_DONE;
                  end else begin
                     break_in = BREAK_W'(LAYOUT_BYTES);
                     state_in = S_INIT_W0;
                  end
               end
               CMD_ALLOC: begin
                  if (req_ff.request_bytes == '0) begin
                     res_status_in = ST_ZERO_SIZE;
                     state_in      = S_DONE;
                  end else if (list_ff == '0) begin
                     res_status_in = ST_NO_MEMORY;
                     state_in      = S_DONE;
                  end else begin
                     asize_in = (WORD_W'(req_ff.request_bytes) + 32'd15) & SIZE_MASK;
                     bp_in    = rover32;
                     n_in     = '0;
                     phase_in = 1'b0;
                     state_in = S_SRCH_RD;
                  end
               end
               CMD_FREE: begin
                  bp_in = WORD_W'(req_ff.block_address);
                  if (list_ff == '0 || req_ff.block_address[2:0] != 3'd0 ||
                      req_ff.block_address <= list_ff ||
                      BREAK_W'(req_ff.block_address) >= break_ff) begin
                     state_in = S_DONE;
                  end else begin
                     state_in = S_FREE_RD;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_INIT_W0: begin
            ram_we    = 1'b1;
            ram_waddr = widx(32'd0);
            ram_wdata = PAD_WORD;
            state_in  = S_INIT_W1;
         end
         S_INIT_W1: begin
            ram_we    = 1'b1;
            ram_waddr = widx(32'd4);
            ram_wdata = PROLOGUE_TAG;
            state_in  = S_INIT_W2;
         end
         S_INIT_W2: begin
            ram_we    = 1'b1;
            ram_waddr = widx(32'd8);
            ram_wdata = PROLOGUE_TAG;
            state_in  = S_INIT_W3;
         end
         S_INIT_W3: begin
            ram_we    = 1'b1;
            ram_waddr = widx(32'd12);
            ram_wdata = ALLOC_BIT;
            list_in   = LIST_START_OK;
            ext_in    = chunk32;
            ctx_in    = CTX_INIT;
            state_in  = S_EXT;
         end
         S_EXT: begin
            if (grow_sum > {1'b0, limit}) begin
               if (ctx_ff == CTX_INIT) begin
                  break_in      = '0;
                  rover_in      = '0;
                  list_in       = '0;
                  res_status_in = ST_INIT_FAIL;
               end else begin
                  res_status_in = ST_NO_MEMORY;
               end
               res_addr_in = '0;
               state_in    = S_DONE;
            end else begin
               bp_in    = break32;
               msize_in = esize;
               break_in = grow_sum[BREAK_W-1:0];
               state_in = S_EXT_W0;
            end
         end
         S_EXT_W0: begin
            ram_we    = 1'b1;
            ram_waddr = widx(bp_ff - 32'd4);
            ram_wdata = msize_ff;
            state_in  = S_EXT_W1;
         end
         S_EXT_W1: begin
            ram_we    = 1'b1;
            ram_waddr = widx(bp_ff + msize_ff - 32'd8);
            ram_wdata = msize_ff;
            state_in  = S_EXT_W2;
         end
         S_EXT_W2: begin
            ram_we    = 1'b1;
            ram_waddr = widx(bp_ff + msize_ff - 32'd4);
            ram_wdata = ALLOC_BIT;
            state_in  = S_MRG_A;
         end
         S_MRG_A: begin
            ram_raddr = widx(bp_ff - 32'd4);
            state_in  = S_MRG_B;
         end
         S_MRG_B: begin
            msize_in  = rd_size;
            ram_raddr = widx(bp_ff - 32'd8);
            state_in  = S_MRG_C;
         end
         S_MRG_C: begin
            prev_in   = ram_rdata;
            ram_raddr = widx(bp_ff + msize_ff - 32'd4);
            state_in  = S_MRG_D;
         end
         S_MRG_D: begin
            if (prev_ff[0] && ram_rdata[0]) begin
               state_in = S_MRG_RET;
            end else begin
               msize_in = tot;
               if (!prev_ff[0]) begin
                  bp_in = bp_ff - (prev_ff & SIZE_MASK);
               end
               state_in = S_MRG_W0;
            end
         end
         S_MRG_W0: begin
            ram_we    = 1'b1;
            ram_waddr = widx(bp_ff - 32'd4);
            ram_wdata = msize_ff;
            state_in  = S_MRG_W1;
         end
         S_MRG_W1: begin
            ram_we    = 1'b1;
            ram_waddr = widx(bp_ff + msize_ff - 32'd8);
            ram_wdata = msize_ff;
            rover_in  = bp_ff[ADDR_W-1:0];
            state_in  = S_MRG_RET;
         end
         S_MRG_RET: begin
            unique case (ctx_ff)
               CTX_INIT: begin
                  rover_in      = list_ff;
                  res_status_in = ST_OK;
                  state_in      = S_DONE;
               end
               CTX_ALLOC: begin
                  state_in = S_CARVE_A;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_SRCH_RD: begin
            if (!phase_ff) begin
               if (n_ff >= N_MAX) begin
                  phase_in = 1'b1;
                  bp_in    = list32;
               end else begin
                  ram_raddr = widx(bp_ff - 32'd4);
                  state_in  = S_SRCH_CHK;
               end
            end else if (bp_ff < rover32 && n_ff < N_MAX) begin
               ram_raddr = widx(bp_ff - 32'd4);
               state_in  = S_SRCH_CHK;
            end else begin
               ext_in   = ext_pick;
               ctx_in   = CTX_ALLOC;
               state_in = S_EXT;
            end
         end
         S_SRCH_CHK: begin
            if (!phase_ff && rd_size == '0) begin
               phase_in = 1'b1;
               bp_in    = list32;
               state_in = S_SRCH_RD;
            end else if (!ram_rdata[0] && rd_size >= asize_ff) begin
               rover_in = bp_ff[ADDR_W-1:0];
               state_in = S_CARVE_A;
            end else begin
               bp_in    = bp_ff + rd_size;
               n_in     = n_ff + 1'b1;
               state_in = S_SRCH_RD;
            end
         end
         S_CARVE_A: begin
            ram_raddr = widx(bp_ff - 32'd4);
            state_in  = S_CARVE_B;
         end
         S_CARVE_B: begin
            msize_in = rd_size;
            split_in = (rd_size >= asize_ff) && ((rd_size - asize_ff) >= MIN_BLOCK);
            state_in = S_CARVE_W0;
         end
         S_CARVE_W0: begin
            ram_we    = 1'b1;
            ram_waddr = widx(bp_ff - 32'd4);
            ram_wdata = (split_ff ? asize_ff : msize_ff) | ALLOC_BIT;
            state_in  = S_CARVE_W1;
         end
         S_CARVE_W1: begin
            ram_we        = 1'b1;
            ram_waddr     = widx(bp_ff + (split_ff ? asize_ff : msize_ff) - 32'd8);
            ram_wdata     = (split_ff ? asize_ff : msize_ff) | ALLOC_BIT;
            res_addr_in   = bp_ff[ADDR_W-1:0];
            res_status_in = ST_OK;
            state_in      = split_ff ? S_CARVE_W2 : S_DONE;
         end
         S_CARVE_W2: begin
            ram_we    = 1'b1;
            ram_waddr = widx(bp_ff + asize_ff - 32'd4);
            ram_wdata = msize_ff - asize_ff;
            state_in  = S_CARVE_W3;
         end
         S_CARVE_W3: begin
            ram_we    = 1'b1;
            ram_waddr = widx(bp_ff + msize_ff - 32'd8);
            ram_wdata = msize_ff - asize_ff;
            rover_in  = ADDR_W'(bp_ff + asize_ff);
            state_in  = S_DONE;
         end
         S_FREE_RD: begin
            ram_raddr = widx(bp_ff - 32'd4);
            state_in  = S_FREE_CHK;
         end
         S_FREE_CHK: begin
            msize_in = rd_size;
            if (!ram_rdata[0] || rd_size < MIN_BLOCK ||
                end_sum > (WORD_W+1)'(break_ff)) begin
               state_in = S_DONE;
            end else begin
               state_in = S_FREE_W0;
            end
         end
         S_FREE_W0: begin
            ram_we    = 1'b1;
            ram_waddr = widx(bp_ff - 32'd4);
            ram_wdata = msize_ff;
            state_in  = S_FREE_W1;
         end
         S_FREE_W1: begin
            ram_we    = 1'b1;
            ram_waddr = widx(bp_ff + msize_ff - 32'd8);
            ram_wdata = msize_ff;
            ctx_in    = CTX_FREE;
            state_in  = S_MRG_A;
         end
         S_DONE: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign ready               = (state_ff == S_IDLE);
   assign rsp.payload_address = res_addr_ff;
   assign rsp.status          = res_status_ff;

endmodule

[rtl/next_fit_boundary_tag_allocator_core.sv]
// ----------------------------------------------------------------------------
// next_fit_boundary_tag_allocator_core
// Next-fit heap allocator with header/footer boundary tags in a word RAM.
//
// Commands arrive on the req_ channel (init, allocate, free); each transfer
// yields exactly one transfer on the rsp_ channel with a payload address and
// a status. One command is worked at a time by a sequencer that reads and
// writes at most one heap word per cycle through a single RAM read and write port.
// A free may merge with free neighbours; an allocate visits block headers
// from the rover, may split the block it takes, and on a miss extends the
// heap, merging the new space with a free neighbour, before it carves.
// req_stall is high while a command is in work; the next command can be
// taken at the earliest in the same cycle as the previous result appears.
// A finished result sits in the output register; the next command can be
// taken while it waits, and the sequencer holds its next result until the
// output register frees up. rsp_stall delays the result transfer and so the next result.
// Reset clears the break, rover and list start (no usable heap) and loads
// default configuration; the heap RAM is not cleared, init lays it out.
// The user must write configuration through csr_ only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module next_fit_boundary_tag_allocator_core
   import nfa_pkg::*;
#(
   parameter int HEAP_WORDS = HEAP_WORDS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_payload_type    req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_payload_type    rsp_payload,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [BREAK_W-1:0] csr_write_data
);

   localparam int AW = $clog2(HEAP_WORDS);

   cfg_type         cfg_ff, cfg_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic            seq_ready;
   logic            seq_done;
   logic            seq_start;
   logic            out_free;
   rsp_payload_type seq_rsp;
   logic            ram_we;
   logic [AW-1:0]   ram_waddr;
   logic [WORD_W-1:0] ram_wdata;
   logic [AW-1:0]   ram_raddr;
   logic [WORD_W-1:0] ram_rdata;

   assign req_stall = !seq_ready;
   assign seq_start = req_valid && seq_ready;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_HEAP_LIMIT: cfg_in.heap_limit_bytes = csr_write_data;
            CSR_CHUNK:      cfg_in.chunk_bytes      = csr_write_data[CHUNK_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (seq_done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = seq_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.heap_limit_bytes <= HEAP_LIMIT_RST;
         cfg_ff.chunk_bytes      <= CHUNK_RST;
         rsp_valid_ff            <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   nfa_ram #(
      .WIDTH (WORD_W),
      .DEPTH (HEAP_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   nfa_seq #(
      .HEAP_WORDS (HEAP_WORDS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (seq_start),
      .req       (req_payload),
      .cfg       (cfg_ff),
      .out_free  (out_free),
      .ready     (seq_ready),
      .done      (seq_done),
      .rsp       (seq_rsp),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   a_fail_no_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != ST_OK |-> rsp_payload.payload_address == '0)
      else $error("failed command returned an address");

   a_addr_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.payload_address[2:0] == 3'd0)
      else $error("payload address not 8-byte aligned");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("sequencer ready right after taking a command");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      seq_done |=> rsp_valid)
      else $error("finished result not presented");

endmodule
